FILE: src/hsa_pkg.sv
`timescale 1ns / 1ps

package hsa_pkg;

	// default pool geometry and field widths
	localparam int SLOT_COUNT_LOG_DEF = 10;
	localparam int HASH_W             = 64;
	localparam int SIZE_W             = 16;
	localparam int SLOT_W             = 10;
	localparam int STATUS_W           = 3;
	localparam int CMD_W              = 2;
	localparam int POS_W              = 5;

	// register file
	localparam int               CFG_ADDR_W    = 3;
	localparam int               CFG_DATA_W    = 32;
	localparam logic [0:0]       REG_SLOT_SIZE = 1'b0;
	localparam logic [SIZE_W-1:0] SLOT_SIZE_RST = 16'd64;

	typedef enum logic [CMD_W-1:0] {
		CMD_ALLOC    = 2'd0,
		CMD_FREE     = 2'd1,
		CMD_DESTRUCT = 2'd2
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK          = 3'd0,
		ST_WRONG_SIZE  = 3'd1,
		ST_DESTRUCTED  = 3'd2,
		ST_FULL        = 3'd3,
		ST_DOUBLE_FREE = 3'd4,
		ST_UNDERFLOW   = 3'd5
	} status_t;

	// result of one bitmap word scan
	typedef struct packed {
		logic             found;
		logic [POS_W-1:0] pos;
	} scan_res_t;

endpackage

FILE: src/hsa_if.sv
`timescale 1ns / 1ps

// command channel
interface hsa_req_if;
	import hsa_pkg::*;
	logic                valid;
	logic                ready;
	logic [CMD_W-1:0]    cmd;
	logic [SIZE_W-1:0]   request_size;
	logic [HASH_W-1:0]   key_hash;
	logic [SLOT_W-1:0]   release_slot;

	modport source (output valid, cmd, request_size, key_hash, release_slot, input ready);
	modport sink (input valid, cmd, request_size, key_hash, release_slot, output ready);
endinterface

// response channel
interface hsa_rsp_if;
	import hsa_pkg::*;
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [SLOT_W-1:0]   granted_slot;
	logic                pool_drained;

	modport source (output valid, status, granted_slot, pool_drained, input ready);
	modport sink (input valid, status, granted_slot, pool_drained, output ready);
endinterface

FILE: src/hashed_slot_allocator_unit.sv
`timescale 1ns / 1ps

// Slot pool allocator with a taken bitmap held in a word-wide memory.
// After reset the block clears the bitmap, one word per cycle, through all
// 2^SLOT_COUNT_LOG/32 words (32 at the default size; below 64 slots the bitmap
// is two words of 2^(SLOT_COUNT_LOG-1) bits) with req.ready low;
// register writes are taken meanwhile.
// An allocate probes from the slot picked by the top bits of key_hash,
// one bitmap word per cycle through a single scan unit on the memory read
// port, visiting from 1 up to words+1 words for a full pass. A free reads
// the word, then writes it back. Destruct, rejected allocates and the
// unused command code answer without a memory access. One transaction
// is in work at a time.
module hashed_slot_allocator_unit #(
	parameter int SLOT_COUNT_LOG = hsa_pkg::SLOT_COUNT_LOG_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	hsa_req_if.sink                        req,
	hsa_rsp_if.source                      rsp,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [hsa_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [hsa_pkg::CFG_DATA_W-1:0] pwdata,
	output logic [hsa_pkg::CFG_DATA_W-1:0] prdata,
	output logic                           pready
);
	import hsa_pkg::*;

	localparam int N         = SLOT_COUNT_LOG;
	localparam int LOG_W     = (N - 1 < POS_W) ? N - 1 : POS_W;
	localparam int WORD_W    = 1 << LOG_W;
	localparam int ADDR_W    = N - LOG_W;
	localparam int WORDS     = 1 << ADDR_W;
	localparam int VIS_W     = ADDR_W + 1;
	localparam int CNT_W     = N + 1;
	localparam int REL_EXT_W = N + SLOT_W;

	typedef enum logic [3:0] {
		S_CLEAR = 4'b0001,
		S_IDLE  = 4'b0010,
		S_PROBE = 4'b0100,
		S_FREE  = 4'b1000
	} state_t;

	state_t             state_q, state_d;
	logic [ADDR_W-1:0]  word_q, word_d;
	logic [LOG_W-1:0]   bit_q, bit_d;
	logic [VIS_W-1:0]   vis_q, vis_d;
	logic [CNT_W-1:0]   cnt_q, cnt_d;
	logic               destr_q, destr_d;
	logic [ADDR_W-1:0]  clr_q, clr_d;

	logic               rsp_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [SLOT_W-1:0]  slot_q;
	logic               drained_q;

	logic               res_load;
	status_t            res_status;
	logic [N-1:0]       res_slot;
	logic               res_drained;
	logic [REL_EXT_W-1:0] res_ext;

	logic               wr_en, rd_en;
	logic [ADDR_W-1:0]  wr_addr, rd_addr;
	logic [WORD_W-1:0]  wr_data, rd_data;
	logic [WORD_W-1:0]  eligible;
	scan_res_t          scan;
	logic [LOG_W-1:0]   free_pos;

	logic [SIZE_W-1:0]  slot_size;
	logic               accept;
	logic [N-1:0]       start_slot;
	logic [REL_EXT_W-1:0] rel_ext;
	logic               rel_oor;
	logic [N-1:0]       rel_idx;

	hsa_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.slot_size (slot_size)
	);

	hsa_bitmap #(
		.ADDR_W (ADDR_W),
		.WORD_W (WORD_W)
	) u_bitmap (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	hsa_scan #(
		.WORD_W (WORD_W)
	) u_scan (
		.taken    (rd_data),
		.eligible (eligible),
		.res      (scan)
	);

	// handshake: a new transaction only when idle and the response slot drains
	assign req.ready = (state_q == S_IDLE) && (!rsp_valid_q || rsp.ready);
	assign accept    = req.valid && req.ready;

	// request decode
	assign start_slot = req.key_hash[HASH_W-1 -: N];
	assign rel_ext    = {{N{1'b0}}, req.release_slot};
	assign rel_oor    = |rel_ext[REL_EXT_W-1:N];
	assign rel_idx    = rel_ext[N-1:0];

	// first visit of the start word skips bits below the start slot
	assign eligible = (vis_q == '0) ? ({WORD_W{1'b1}} << bit_q) : {WORD_W{1'b1}};
	assign free_pos = scan.pos[LOG_W-1:0];

	// sequencer
	always_comb begin
		state_d     = state_q;
		word_d      = word_q;
		bit_d       = bit_q;
		vis_d       = vis_q;
		cnt_d       = cnt_q;
		destr_d     = destr_q;
		clr_d       = clr_q;
		wr_en       = 1'b0;
		wr_addr     = word_q;
		wr_data     = '0;
		rd_en       = 1'b0;
		rd_addr     = word_q;
		res_load    = 1'b0;
		res_status  = ST_OK;
		res_slot    = '0;
		res_drained = 1'b0;

		unique case (state_q)
			S_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
				clr_d   = clr_q + 1'b1;
				if (clr_q == ADDR_W'(WORDS - 1)) begin
					state_d = S_IDLE;
				end
			end

			S_IDLE: begin
				if (accept) begin
					unique case (req.cmd)
						CMD_ALLOC: begin
							if (req.request_size != slot_size) begin
								res_load   = 1'b1;
								res_status = ST_WRONG_SIZE;
							end else if (destr_q) begin
								res_load   = 1'b1;
								res_status = ST_DESTRUCTED;
							end else begin
								rd_en   = 1'b1;
								rd_addr = start_slot[N-1:LOG_W];
								word_d  = start_slot[N-1:LOG_W];
								bit_d   = start_slot[LOG_W-1:0];
								vis_d   = '0;
								state_d = S_PROBE;
							end
						end
						CMD_FREE: begin
							if (rel_oor) begin
								res_load   = 1'b1;
								res_status = ST_DOUBLE_FREE;
							end else begin
								rd_en   = 1'b1;
								rd_addr = rel_idx[N-1:LOG_W];
								word_d  = rel_idx[N-1:LOG_W];
								bit_d   = rel_idx[LOG_W-1:0];
								state_d = S_FREE;
							end
						end
						CMD_DESTRUCT: begin
							res_load = 1'b1;
							if (!destr_q) begin
								destr_d     = 1'b1;
								res_drained = (cnt_q == '0);
							end
						end
						default: begin
							res_load = 1'b1;
						end
					endcase
				end
			end

			S_PROBE: begin
				if (scan.found) begin
					wr_en    = 1'b1;
					wr_data  = rd_data | (WORD_W'(1) << free_pos);
					cnt_d    = cnt_q + 1'b1;
					res_load = 1'b1;
					res_slot = {word_q, free_pos};
					state_d  = S_IDLE;
				end else if (vis_q == VIS_W'(WORDS)) begin
					res_load   = 1'b1;
					res_status = ST_FULL;
					state_d    = S_IDLE;
				end else begin
					rd_en   = 1'b1;
					rd_addr = word_q + 1'b1;
					word_d  = word_q + 1'b1;
					vis_d   = vis_q + 1'b1;
				end
			end

			S_FREE: begin
				res_load = 1'b1;
				state_d  = S_IDLE;
				if (!rd_data[bit_q]) begin
					res_status = ST_DOUBLE_FREE;
				end else begin
					wr_en   = 1'b1;
					wr_data = rd_data & ~(WORD_W'(1) << bit_q);
					if (cnt_q == '0) begin
						res_status = ST_UNDERFLOW;
					end else begin
						cnt_d       = cnt_q - 1'b1;
						res_drained = destr_q && (cnt_q == CNT_W'(1));
					end
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			word_q  <= '0;
			bit_q   <= '0;
			vis_q   <= '0;
			cnt_q   <= '0;
			destr_q <= 1'b0;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			word_q  <= word_d;
			bit_q   <= bit_d;
			vis_q   <= vis_d;
			cnt_q   <= cnt_d;
			destr_q <= destr_d;
			clr_q   <= clr_d;
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign res_ext = {{SLOT_W{1'b0}}, res_slot};

	always_ff @(posedge clk) begin
		if (res_load) begin
			status_q  <= res_status;
			slot_q    <= res_ext[SLOT_W-1:0];
			drained_q <= res_drained;
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.status       = status_q;
	assign rsp.granted_slot = slot_q;
	assign rsp.pool_drained = drained_q;

endmodule

FILE: src/hsa_cfg.sv
`timescale 1ns / 1ps

module hsa_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [hsa_pkg::CFG_ADDR_W-1:0]   paddr,
	input  logic [hsa_pkg::CFG_DATA_W-1:0]   pwdata,
	output logic [hsa_pkg::CFG_DATA_W-1:0]   prdata,
	output logic                             pready,
	output logic [hsa_pkg::SIZE_W-1:0]       slot_size
);
	import hsa_pkg::*;

	logic [SIZE_W-1:0] slot_size_q;
	logic              reg_hit;

	assign reg_hit = (paddr[CFG_ADDR_W-1:2] == REG_SLOT_SIZE);
	assign pready  = 1'b1;

	// register write on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_size_q <= SLOT_SIZE_RST;
		end else if (psel && penable && pwrite && reg_hit) begin
			slot_size_q <= pwdata[SIZE_W-1:0];
		end
	end

	// read-back
	always_comb begin
		prdata = '0;
		if (reg_hit) begin
			prdata = {{(CFG_DATA_W-SIZE_W){1'b0}}, slot_size_q};
		end
	end

	assign slot_size = slot_size_q;

endmodule

FILE: src/hsa_bitmap.sv
`timescale 1ns / 1ps

// taken bitmap, one word written and one word read per cycle
module hsa_bitmap #(
	parameter int ADDR_W = 5,
	parameter int WORD_W = 32
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WORD_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WORD_W-1:0] rd_data
);
	localparam int DEPTH = 1 << ADDR_W;

	logic [WORD_W-1:0] mem [DEPTH];
	logic [WORD_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: src/hsa_scan.sv
`timescale 1ns / 1ps

// lowest free bit among the eligible bits of one bitmap word
module hsa_scan #(
	parameter int WORD_W = 32
) (
	input  logic [WORD_W-1:0]  taken,
	input  logic [WORD_W-1:0]  eligible,
	output hsa_pkg::scan_res_t res
);
	import hsa_pkg::*;

	always_comb begin
		res = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (!taken[i] && eligible[i]) begin
				res.found = 1'b1;
				res.pos   = POS_W'(i);
			end
		end
	end

endmodule

FILE: tb/sv/hashed_slot_allocator_unit_tb.sv
`timescale 1ns / 1ps

module hashed_slot_allocator_unit_tb;
	import hsa_pkg::*;

	localparam int POOL_LOG = SLOT_COUNT_LOG_DEF;
	localparam int POOL_SLOTS = 1 << POOL_LOG;
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam logic [CFG_ADDR_W-1:0] SLOT_SIZE_ADDR = {REG_SLOT_SIZE, 2'b00};
	// allow far more quiet cycles than a full probe pass plus stalls and gaps
	localparam int QUIET_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 40;

	typedef struct {
		logic [CMD_W-1:0]  cmd;
		logic [SIZE_W-1:0] request_size;
		logic [HASH_W-1:0] key_hash;
		logic [SLOT_W-1:0] release_slot;
	} pool_cmd_t;

	typedef struct {
		status_t           status;
		logic [SLOT_W-1:0] granted_slot;
		logic              pool_drained;
	} pool_rsp_t;

	logic clk = 1'b0;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [CFG_ADDR_W-1:0] paddr;
	logic [CFG_DATA_W-1:0] pwdata;
	logic [CFG_DATA_W-1:0] prdata;
	logic pready;

	hsa_req_if cmd_chan ();
	hsa_rsp_if resp_chan ();

	hashed_slot_allocator_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (cmd_chan),
		.rsp     (resp_chan),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// shadow pool state
	bit slot_busy [POOL_SLOTS];
	logic [POOL_LOG:0] live_count = '0;
	bit pool_closed = 1'b0;
	logic [SIZE_W-1:0] slot_size_cfg = SLOT_SIZE_RST;

	pool_cmd_t cmd_backlog[$];
	pool_rsp_t awaited_rsp[$];
	int busy_pool[$];
	int txn_in_flight = 0;
	int fail_count = 0;
	int quiet_cycles = 0;
	int src_gap = 0;
	int sink_stall = 0;
	bit src_gaps_on = 1'b1;
	bit sink_stalls_on = 1'b1;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// expected response for one command; updates the shadow state
	function automatic pool_rsp_t predict_response(input pool_cmd_t rq);
		pool_rsp_t r;
		logic [POOL_LOG-1:0] start;
		logic [POOL_LOG-1:0] idx;
		bit found;
		int n;
		r.status = ST_OK;
		r.granted_slot = '0;
		r.pool_drained = 1'b0;
		case (rq.cmd)
			CMD_ALLOC: begin
				if (rq.request_size != slot_size_cfg) begin
					r.status = ST_WRONG_SIZE;
				end else if (pool_closed) begin
					r.status = ST_DESTRUCTED;
				end else begin
					// linear probe with wraparound, one full pass at most
					r.status = ST_FULL;
					start = rq.key_hash[HASH_W-1 -: POOL_LOG];
					found = 1'b0;
					for (n = 0; n < POOL_SLOTS && !found; n++) begin
						idx = start + n[POOL_LOG-1:0];
						if (!slot_busy[idx]) begin
							slot_busy[idx] = 1'b1;
							live_count++;
							r.status = ST_OK;
							r.granted_slot = SLOT_W'(idx);
							found = 1'b1;
						end
					end
				end
			end
			CMD_FREE: begin
				if (!slot_busy[rq.release_slot]) begin
					r.status = ST_DOUBLE_FREE;
				end else begin
					// bit is cleared even when the count has nothing to give
					slot_busy[rq.release_slot] = 1'b0;
					if (live_count == 0) begin
						r.status = ST_UNDERFLOW;
					end else begin
						live_count--;
						r.pool_drained = pool_closed && (live_count == 0);
					end
				end
			end
			CMD_DESTRUCT: begin
				if (!pool_closed) begin
					pool_closed = 1'b1;
					r.pool_drained = (live_count == 0);
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	// command driver
	always @(posedge clk or negedge arst_n) begin : feed
		pool_cmd_t nxt;
		if (!arst_n) begin
			cmd_chan.valid <= 1'b0;
			cmd_chan.cmd <= '0;
			cmd_chan.request_size <= '0;
			cmd_chan.key_hash <= '0;
			cmd_chan.release_slot <= '0;
			src_gap <= 0;
		end else if (!cmd_chan.valid || cmd_chan.ready) begin
			if (src_gap != 0) begin
				cmd_chan.valid <= 1'b0;
				src_gap <= src_gap - 1;
			end else if (cmd_backlog.size() != 0) begin
				nxt = cmd_backlog.pop_front();
				cmd_chan.cmd <= nxt.cmd;
				cmd_chan.request_size <= nxt.request_size;
				cmd_chan.key_hash <= nxt.key_hash;
				cmd_chan.release_slot <= nxt.release_slot;
				cmd_chan.valid <= 1'b1;
				if (src_gaps_on && $urandom_range(0, 5) == 0)
					src_gap <= $urandom_range(1, 9);
			end else begin
				cmd_chan.valid <= 1'b0;
			end
		end
	end

	// response backpressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			resp_chan.ready <= 1'b0;
			sink_stall <= 0;
		end else if (sink_stall != 0) begin
			resp_chan.ready <= 1'b0;
			sink_stall <= sink_stall - 1;
		end else begin
			resp_chan.ready <= 1'b1;
			if (sink_stalls_on && $urandom_range(0, 6) == 0)
				sink_stall <= $urandom_range(1, 9);
		end
	end

	// monitor: predict on accepted commands, then check responses in order
	always @(posedge clk) begin : observe
		pool_cmd_t seen;
		pool_rsp_t want;
		if (arst_n) begin
			if (cmd_chan.valid && cmd_chan.ready) begin
				seen.cmd = cmd_chan.cmd;
				seen.request_size = cmd_chan.request_size;
				seen.key_hash = cmd_chan.key_hash;
				seen.release_slot = cmd_chan.release_slot;
				awaited_rsp.push_back(predict_response(seen));
			end
			if (resp_chan.valid && resp_chan.ready) begin
				if (awaited_rsp.size() == 0) begin
					$error("response transaction with none expected: status %0d slot %0d",
						resp_chan.status, resp_chan.granted_slot);
					fail_count++;
				end else begin
					want = awaited_rsp.pop_front();
					txn_in_flight--;
					if (resp_chan.status !== want.status) begin
						$error("status mismatch: expected %0d, actual %0d",
							want.status, resp_chan.status);
						fail_count++;
					end
					if (resp_chan.granted_slot !== want.granted_slot) begin
						$error("granted_slot mismatch: expected %0d, actual %0d",
							want.granted_slot, resp_chan.granted_slot);
						fail_count++;
					end
					if (resp_chan.pool_drained !== want.pool_drained) begin
						$error("pool_drained mismatch: expected %0d, actual %0d",
							want.pool_drained, resp_chan.pool_drained);
						fail_count++;
					end
				end
			end
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((cmd_chan.valid && cmd_chan.ready) || (resp_chan.valid && resp_chan.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic push_req(input logic [CMD_W-1:0] c, input logic [SIZE_W-1:0] sz,
			input logic [HASH_W-1:0] h, input logic [SLOT_W-1:0] s);
		pool_cmd_t it;
		it.cmd = c;
		it.request_size = sz;
		it.key_hash = h;
		it.release_slot = s;
		cmd_backlog.push_back(it);
		txn_in_flight++;
	endtask

	// half random starts, a quarter near the top to force wraparound, a quarter clustered low
	function automatic logic [HASH_W-1:0] pick_hash();
		logic [HASH_W-1:0] h;
		h = {$urandom, $urandom};
		case ($urandom_range(0, 3))
			0: h[HASH_W-1 -: POOL_LOG] = POOL_LOG'(POOL_SLOTS - 1 - $urandom_range(0, 7));
			1: h[HASH_W-1 -: POOL_LOG] = POOL_LOG'($urandom_range(0, 15));
			default: ;
		endcase
		return h;
	endfunction

	task automatic push_alloc(input logic [HASH_W-1:0] h);
		push_req(CMD_ALLOC, slot_size_cfg, h, SLOT_W'($urandom));
	endtask

	task automatic push_free(input logic [SLOT_W-1:0] s);
		push_req(CMD_FREE, SIZE_W'($urandom), {$urandom, $urandom}, s);
	endtask

	task automatic push_noise_cmd(input logic [CMD_W-1:0] c);
		push_req(c, SIZE_W'($urandom), {$urandom, $urandom}, SLOT_W'($urandom));
	endtask

	task automatic wait_settled();
		while (txn_in_flight != 0)
			@(posedge clk);
	endtask

	// list of slots currently held, taken only while the pool is idle
	task automatic snapshot_busy();
		int k;
		busy_pool.delete();
		for (k = 0; k < POOL_SLOTS; k++)
			if (slot_busy[k])
				busy_pool.push_back(k);
	endtask

	function automatic logic [SLOT_W-1:0] take_busy();
		int i;
		logic [SLOT_W-1:0] s;
		i = $urandom_range(0, busy_pool.size() - 1);
		s = SLOT_W'(busy_pool[i]);
		busy_pool.delete(i);
		return s;
	endfunction

	// register write followed by a read back, only with the pool idle
	task automatic write_slot_size(input logic [SIZE_W-1:0] val);
		wait_settled();
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= SLOT_SIZE_ADDR;
		pwdata <= {(CFG_DATA_W-SIZE_W)'($urandom), val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		slot_size_cfg = val;
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata[SIZE_W-1:0] !== val) begin
			$error("slot_size readback mismatch: expected %0d, actual %0d",
				val, prdata[SIZE_W-1:0]);
			fail_count++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// allocates, frees of held and random slots, wrong sizes, unused code
	task automatic run_mixed(input int count);
		int k;
		int pick;
		wait_settled();
		snapshot_busy();
		for (k = 0; k < count; k++) begin
			pick = $urandom_range(0, 99);
			if (pick < 50)
				push_alloc(pick_hash());
			else if (pick < 60)
				push_req(CMD_ALLOC, SIZE_W'($urandom), pick_hash(), SLOT_W'($urandom));
			else if (pick < 85 && busy_pool.size() != 0)
				push_free(take_busy());
			else if (pick < 95)
				push_free(SLOT_W'($urandom));
			else
				push_noise_cmd(CMD_UNUSED);
		end
	endtask

	// allocate past capacity so long probes and full passes occur
	task automatic fill_pool(input int allocs);
		int done;
		int pick;
		done = 0;
		while (done < allocs) begin
			pick = $urandom_range(0, 99);
			if (pick < 4) begin
				push_free(SLOT_W'($urandom));
			end else if (pick < 7) begin
				push_req(CMD_ALLOC, SIZE_W'($urandom), pick_hash(), SLOT_W'($urandom));
			end else begin
				push_alloc(pick_hash());
				done++;
			end
		end
	endtask

	// destruct with slots held, then free every slot; the free emptying the pool drains it
	task automatic close_and_drain();
		push_noise_cmd(CMD_DESTRUCT);
		push_alloc(pick_hash());
		push_req(CMD_ALLOC, slot_size_cfg ^ SIZE_W'($urandom_range(1, 65535)),
			pick_hash(), SLOT_W'($urandom));
		push_noise_cmd(CMD_DESTRUCT);
		wait_settled();
		snapshot_busy();
		while (busy_pool.size() != 0) begin
			if ($urandom_range(0, 19) == 0) begin
				case ($urandom_range(0, 3))
					0: push_free(SLOT_W'($urandom));
					1: push_alloc(pick_hash());
					2: push_noise_cmd(CMD_DESTRUCT);
					default: push_noise_cmd(CMD_UNUSED);
				endcase
			end
			push_free(take_busy());
		end
		push_free(SLOT_W'($urandom));
		push_noise_cmd(CMD_DESTRUCT);
	endtask

	initial begin : stimulus
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		cmd_chan.valid = 1'b0;
		cmd_chan.cmd = '0;
		cmd_chan.request_size = '0;
		cmd_chan.key_hash = '0;
		cmd_chan.release_slot = '0;
		resp_chan.ready = 1'b0;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed checks at the reset slot size
		push_alloc('0);
		push_alloc('1);
		push_alloc('1);
		push_req(CMD_ALLOC, '0, {$urandom, $urandom}, SLOT_W'($urandom));
		push_req(CMD_ALLOC, '1, {$urandom, $urandom}, SLOT_W'($urandom));
		push_req(CMD_ALLOC, slot_size_cfg + 1'b1, '0, '0);
		push_free(SLOT_W'(POOL_SLOTS - 1));
		push_free(SLOT_W'(POOL_SLOTS - 1));
		push_free(SLOT_W'(POOL_SLOTS / 2));
		push_req(CMD_UNUSED, '1, '1, '1);
		push_alloc({POOL_LOG'(POOL_SLOTS / 2), {(HASH_W - POOL_LOG){1'b1}}});
		push_free('0);
		push_free(SLOT_W'(1));
		push_free(SLOT_W'(POOL_SLOTS / 2));

		// random phases across slot size settings, extremes included
		write_slot_size(16'd1);
		run_mixed(70);
		src_gaps_on = 1'b0;
		write_slot_size(16'hFFFF);
		run_mixed(70);
		src_gaps_on = 1'b1;
		sink_stalls_on = 1'b0;
		write_slot_size(SIZE_W'($urandom_range(2, 65534)));
		run_mixed(70);
		sink_stalls_on = 1'b1;
		write_slot_size(SIZE_W'($urandom_range(1, 65535)));
		fill_pool(1100);

		// closing part runs without idling on either side
		wait_settled();
		src_gaps_on = 1'b0;
		sink_stalls_on = 1'b0;
		close_and_drain();

		wait_settled();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

FILE: sim.f
src/hsa_pkg.sv
src/hsa_if.sv
src/hsa_cfg.sv
src/hsa_bitmap.sv
src/hsa_scan.sv
src/hashed_slot_allocator_unit.sv
tb/sv/hashed_slot_allocator_unit_tb.sv
